>>> rtl/scancode_to_ascii_line_editor_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scancode line editor
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_TO_ASCII_LINE_EDITOR_CORE_ASSERT_SVH
`define SCANCODE_TO_ASCII_LINE_EDITOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define SLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define SLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SLE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, key codes and ASCII maps for the scancode line editor.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

    localparam int LINE_LEN_DEF = 32;
    localparam int COUNT_W      = 6;
    localparam int CHAR_W       = 7;
    localparam int KEY_W        = 6;

    localparam logic [KEY_W-1:0] KEY_BACKSPACE = 6'h0E;
    localparam logic [KEY_W-1:0] KEY_ENTER     = 6'h1C;
    localparam logic [KEY_W-1:0] KEY_LSHIFT    = 6'h2A;
    localparam logic [KEY_W-1:0] KEY_RSHIFT    = 6'h36;
    localparam logic [6:0]       KEY_LAST      = 7'd57;

    typedef enum logic [1:0] {
        KIND_ECHO    = 2'd0,
        KIND_ERASE   = 2'd1,
        KIND_NEWLINE = 2'd2,
        KIND_LINE    = 2'd3
    } sle_kind_t;

    // entries above the last key are never selected
    localparam logic [CHAR_W-1:0] PLAIN_MAP [0:63] = '{
        7'h3F, 7'h3F, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h3F, 7'h3F,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h3F, 7'h3F, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h3F, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h3F, 7'h3F,
        7'h3F, 7'h20, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F
    };

    localparam logic [CHAR_W-1:0] SHIFT_MAP [0:63] = '{
        7'h3F, 7'h3F, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h3F, 7'h3F,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h3F, 7'h3F, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h3F, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h3F, 7'h3F,
        7'h3F, 7'h20, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h3F
    };

    // datapath -> controller
    typedef struct packed {
        logic key_valid;
        logic release_key;
        logic shift_key;
        logic backspace;
        logic enter;
        logic line_empty;
        logic line_full;
        logic line_done;
        logic out_free;
    } sle_status_t;

    // controller -> datapath
    typedef struct packed {
        logic      set_shift;
        logic      push_char;
        logic      pop_char;
        logic      clear_line;
        logic      rd_start;
        logic      rd_advance;
        logic      load_out;
        sle_kind_t out_kind;
    } sle_cmd_t;

endpackage

`default_nettype wire

>>> rtl/sle_datapath.sv
// ----------------------------------------------------------------------------
// sle_datapath
// Scancode decode, shift flag, line store, read-out pointer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scancode_to_ascii_line_editor_core_assert.svh"

module sle_datapath #(
    parameter int LINE_LEN = sle_pkg::LINE_LEN_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [7:0]                   scancode,
    input  wire sle_pkg::sle_cmd_t            cmd,
    output sle_pkg::sle_status_t              status,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output logic [1:0]                        kind,
    output logic [sle_pkg::CHAR_W-1:0]        char_code,
    output logic [sle_pkg::COUNT_W-1:0]       line_length,
    output logic                              last
);

    localparam int ADDR_W = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
    localparam logic [sle_pkg::COUNT_W-1:0] LEN_MAX = sle_pkg::COUNT_W'(LINE_LEN);

    logic                            shift_reg,     shift_next;
    logic [sle_pkg::COUNT_W-1:0]     count_reg,     count_next;
    logic [sle_pkg::COUNT_W-1:0]     rd_idx_reg,    rd_idx_next;
    logic [sle_pkg::CHAR_W-1:0]      rd_data_reg;
    logic                            out_valid_reg, out_valid_next;
    sle_pkg::sle_kind_t              out_kind_reg,  out_kind_next;
    logic [sle_pkg::CHAR_W-1:0]      out_char_reg,  out_char_next;
    logic [sle_pkg::COUNT_W-1:0]     out_len_reg,   out_len_next;
    logic                            out_last_reg,  out_last_next;

    logic [sle_pkg::CHAR_W-1:0]      line_mem [LINE_LEN];

    logic                            is_press;
    logic                            is_release;
    logic [sle_pkg::KEY_W-1:0]       key;
    logic [sle_pkg::CHAR_W-1:0]      key_char;
    logic [sle_pkg::COUNT_W-1:0]     rd_idx_inc;
    logic [sle_pkg::COUNT_W-1:0]     rd_addr;
    logic                            out_free;

    // decode: presses 0..57, releases 128..185
    always_comb
    begin
        is_press   = !scancode[7] && (scancode[6:0] <= sle_pkg::KEY_LAST);
        is_release =  scancode[7] && (scancode[6:0] <= sle_pkg::KEY_LAST);
        key        = scancode[sle_pkg::KEY_W-1:0];
        key_char   = shift_reg ? sle_pkg::SHIFT_MAP[key] : sle_pkg::PLAIN_MAP[key];
    end

    assign out_free   = !out_valid_reg || !result_stall;
    assign rd_idx_inc = rd_idx_reg + 6'd1;

    always_comb
    begin
        status.key_valid   = is_press || is_release;
        status.release_key = is_release;
        status.shift_key   = (key == sle_pkg::KEY_LSHIFT) || (key == sle_pkg::KEY_RSHIFT);
        status.backspace   = (key == sle_pkg::KEY_BACKSPACE);
        status.enter       = (key == sle_pkg::KEY_ENTER);
        status.line_empty  = (count_reg == '0);
        status.line_full   = (count_reg >= LEN_MAX);
        status.line_done   = (rd_idx_inc == count_reg);
        status.out_free    = out_free;
    end

    always_comb
    begin
        shift_next     = shift_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        rd_addr        = rd_idx_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_char_next  = out_char_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;

        if (cmd.set_shift)
            shift_next = !is_release;
        if (cmd.push_char)
            count_next = count_reg + 6'd1;
        if (cmd.pop_char)
            count_next = count_reg - 6'd1;
        if (cmd.clear_line)
            count_next = '0;

        if (cmd.rd_start)
        begin
            rd_idx_next = '0;
            rd_addr     = '0;
        end
        else if (cmd.rd_advance)
        begin
            rd_idx_next = rd_idx_inc;
            rd_addr     = rd_idx_inc;
        end

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = cmd.out_kind;
            out_char_next  = '0;
            out_len_next   = '0;
            out_last_next  = 1'b1;
            case (cmd.out_kind)
                sle_pkg::KIND_ECHO:    out_char_next = key_char;
                sle_pkg::KIND_NEWLINE:
                begin
                    out_len_next  = count_reg;
                    out_last_next = (count_reg == '0);
                end
                sle_pkg::KIND_LINE:
                begin
                    out_char_next = rd_data_reg;
                    out_last_next = status.line_done;
                end
                default: ;
            endcase
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg     <= 1'b0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            shift_reg     <= shift_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_char_reg <= out_char_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
    end

    // line store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.push_char)
            line_mem[count_reg[ADDR_W-1:0]] <= key_char;
        rd_data_reg <= line_mem[rd_addr[ADDR_W-1:0]];
    end

    assign result_valid = out_valid_reg;
    assign kind         = 2'(out_kind_reg);
    assign char_code    = out_char_reg;
    assign line_length  = out_len_reg;
    assign last         = out_last_reg;

    `SLE_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= LEN_MAX)
    `SLE_ASSERT_IMPLY(a_load_when_free, clk, rst_n, cmd.load_out, out_free)
    `SLE_ASSERT_NEXT(a_pop_nonempty, clk, rst_n, cmd.pop_char,
                     count_reg == $past(count_reg) - 6'd1)

endmodule

`default_nettype wire

>>> rtl/sle_ctrl.sv
// ----------------------------------------------------------------------------
// sle_ctrl
// Controller: accepts scancodes, sequences echo, erase and line read-out.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scancode_to_ascii_line_editor_core_assert.svh"

module sle_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 scancode_valid,
    output logic                      scancode_stall,
    input  wire sle_pkg::sle_status_t status,
    output sle_pkg::sle_cmd_t         cmd
);

    typedef enum logic {
        S_IDLE,
        S_LINE
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign scancode_stall = !((state_reg == S_IDLE) && status.out_free);
    assign accept         = scancode_valid && !scancode_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_kind = sle_pkg::KIND_ECHO;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && status.key_valid)
                begin
                    if (status.shift_key)
                    begin
                        cmd.set_shift = 1'b1;
                    end
                    else if (!status.release_key)
                    begin
                        if (status.backspace)
                        begin
                            if (!status.line_empty)
                            begin
                                cmd.pop_char = 1'b1;
                                cmd.load_out = 1'b1;
                                cmd.out_kind = sle_pkg::KIND_ERASE;
                            end
                        end
                        else if (status.enter)
                        begin
                            cmd.load_out = 1'b1;
                            cmd.out_kind = sle_pkg::KIND_NEWLINE;
                            if (!status.line_empty)
                            begin
                                cmd.rd_start = 1'b1;
                                state_next   = S_LINE;
                            end
                        end
                        else if (!status.line_full)
                        begin
                            cmd.push_char = 1'b1;
                            cmd.load_out  = 1'b1;
                            cmd.out_kind  = sle_pkg::KIND_ECHO;
                        end
                    end
                end
            end
            S_LINE:
            begin
                // one buffered character per free slot in the result register
                if (status.out_free)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.out_kind   = sle_pkg::KIND_LINE;
                    cmd.rd_advance = 1'b1;
                    if (status.line_done)
                    begin
                        cmd.clear_line = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `SLE_ASSERT_IMPLY(a_line_nonempty, clk, rst_n, state_reg == S_LINE, !status.line_empty)

endmodule

`default_nettype wire

>>> rtl/scancode_to_ascii_line_editor_core.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_line_editor_core
// Set-1 scancode to ASCII line editor with echo, erase and line submission.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake                        | payload
//  ----------+-----+----------------------------------+-----------------------
//  scancode  | in  | scancode_valid / scancode_stall  | scancode[7:0]
//  result    | out | result_valid / result_stall      | kind, char_code,
//            |     |                                  | line_length, last
//
//  A shift, release or ignored item gives nothing.
//  An echo or erase item loads the result register; a further item may enter once the
//  result register is free (the same cycle it is taken).
//  Enter with n buffered characters gives a newline, then one character a cycle
//  from the line store's registered read port while the result register is free.
//  Result stalls hold the result register and block the input.
//  Reset clears shift flag, line count and output valid; the store is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module scancode_to_ascii_line_editor_core #(
    parameter int LINE_LEN = sle_pkg::LINE_LEN_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         scancode_valid,
    output logic                              scancode_stall,
    input  wire logic [7:0]                   scancode,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output logic [1:0]                        kind,
    output logic [sle_pkg::CHAR_W-1:0]        char_code,
    output logic [sle_pkg::COUNT_W-1:0]       line_length,
    output logic                              last
);

    sle_pkg::sle_status_t status;
    sle_pkg::sle_cmd_t    cmd;

    sle_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .scancode_valid (scancode_valid),
        .scancode_stall (scancode_stall),
        .status         (status),
        .cmd            (cmd)
    );

    sle_datapath #(
        .LINE_LEN (LINE_LEN)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .scancode     (scancode),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .char_code    (char_code),
        .line_length  (line_length),
        .last         (last)
    );

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives scancode bytes into the line editor with random gaps and result
// stalls, predicts the echo, erase, newline and submitted-line items, and
// checks every result item in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          CLK_PERIOD     = 10;
    localparam int          LINE_LEN       = sle_pkg::LINE_LEN_DEF;
    localparam int          RANDOM_ITEMS   = 320;
    localparam int          CALM_ITEMS     = 60;
    localparam int          DRAIN_CYCLES   = 40;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          NUM_DIRECTED   = 25;
    localparam logic [7:0]  RELEASE_BIT    = 8'h80;
    localparam logic [7:0]  SC_BACKSPACE   = {2'b00, sle_pkg::KEY_BACKSPACE};
    localparam logic [7:0]  SC_ENTER       = {2'b00, sle_pkg::KEY_ENTER};
    localparam logic [7:0]  SC_LSHIFT      = {2'b00, sle_pkg::KEY_LSHIFT};
    localparam logic [7:0]  SC_RSHIFT      = {2'b00, sle_pkg::KEY_RSHIFT};
    localparam logic [7:0]  SC_LAST        = {1'b0, sle_pkg::KEY_LAST};
    localparam logic [7:0]  SC_FIRST_LETTER = 8'h10;

    typedef struct packed {
        sle_pkg::sle_kind_t kind;
        logic [6:0]         ch;
        logic [5:0]         len;
        logic               last;
    } line_event_t;

    typedef struct packed {
        logic [7:0]  code;
        logic        typed;
        logic        has_event;
        line_event_t ev;
    } key_row_t;

    logic        clk;
    logic        rst_n;
    logic        scancode_valid;
    logic        scancode_stall;
    logic [7:0]  scancode;
    logic        result_valid;
    logic        result_stall;
    logic [1:0]  kind;
    logic [6:0]  char_code;
    logic [5:0]  line_length;
    logic        last;

    scancode_to_ascii_line_editor_core #(
        .LINE_LEN (LINE_LEN)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .scancode_valid (scancode_valid),
        .scancode_stall (scancode_stall),
        .scancode       (scancode),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .kind           (kind),
        .char_code      (char_code),
        .line_length    (line_length),
        .last           (last)
    );

    // ASCII per key, indexed by press code 0..57
    string plain_keys = "??1234567890-=??qwertyuiop[]??asdfghjkl;'`?\\zxcvbnm,./??? ";
    string shift_keys = "??!@#$%^&*()_+??QWERTYUIOP{}??ASDFGHJKL:\"~?|ZXCVBNM<>???? ";

    // editor state as predicted
    bit          shift_on;
    logic [6:0]  typed_line [LINE_LEN];
    int          line_fill;

    line_event_t awaited_outputs [$];
    line_event_t fresh_outputs [$];

    // payload tag of the item on the input port
    logic        cur_typed;
    logic        cur_has_event;
    line_event_t cur_event;

    bit          calm_tail;
    int          mismatches;
    int          quiet_cycles;
    int          items_sent;

    key_row_t directed_rows [NUM_DIRECTED] = '{
        '{8'h00, 1'b1, 1'b1, '{sle_pkg::KIND_ECHO, 7'h3F, 6'd0, 1'b1}},
        '{SC_BACKSPACE, 1'b1, 1'b1, '{sle_pkg::KIND_ERASE, 7'h00, 6'd0, 1'b1}},
        '{SC_BACKSPACE, 1'b1, 1'b0, '0},                                   // empty line
        '{SC_ENTER, 1'b1, 1'b1, '{sle_pkg::KIND_NEWLINE, 7'h00, 6'd0, 1'b1}}, // empty line
        '{8'hFF, 1'b1, 1'b0, '0},
        '{8'h3A, 1'b1, 1'b0, '0},
        '{8'h7F, 1'b1, 1'b0, '0},
        '{8'hBA, 1'b1, 1'b0, '0},
        '{SC_LAST, 1'b1, 1'b1, '{sle_pkg::KIND_ECHO, 7'h20, 6'd0, 1'b1}},
        '{SC_LSHIFT, 1'b1, 1'b0, '0},
        '{8'h1E, 1'b1, 1'b1, '{sle_pkg::KIND_ECHO, 7'h41, 6'd0, 1'b1}},    // 'A'
        '{RELEASE_BIT | SC_LSHIFT, 1'b1, 1'b0, '0},
        '{SC_RSHIFT, 1'b1, 1'b0, '0},
        '{8'h02, 1'b1, 1'b1, '{sle_pkg::KIND_ECHO, 7'h21, 6'd0, 1'b1}},    // '!'
        '{RELEASE_BIT | SC_RSHIFT, 1'b1, 1'b0, '0},
        '{8'h9E, 1'b1, 1'b0, '0},
        '{RELEASE_BIT, 1'b1, 1'b0, '0},
        '{RELEASE_BIT | SC_LAST, 1'b1, 1'b0, '0},
        '{8'h01, 1'b1, 1'b1, '{sle_pkg::KIND_ECHO, 7'h3F, 6'd0, 1'b1}},    // esc
        '{8'h1D, 1'b1, 1'b1, '{sle_pkg::KIND_ECHO, 7'h3F, 6'd0, 1'b1}},    // ctrl
        '{8'h37, 1'b1, 1'b1, '{sle_pkg::KIND_ECHO, 7'h3F, 6'd0, 1'b1}},    // keypad star
        '{8'h0F, 1'b1, 1'b1, '{sle_pkg::KIND_ECHO, 7'h3F, 6'd0, 1'b1}},    // tab
        '{8'h1E, 1'b1, 1'b1, '{sle_pkg::KIND_ECHO, 7'h61, 6'd0, 1'b1}},    // 'a'
        '{SC_ENTER, 1'b0, 1'b0, '0},
        '{SC_BACKSPACE, 1'b1, 1'b0, '0}
    };

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void predict_keystroke(input logic [7:0] code);
        logic [7:0] key;
        bit         released;
        logic [6:0] ch;
        key      = code;
        released = 1'b0;
        if (code >= RELEASE_BIT && code <= RELEASE_BIT + SC_LAST)
        begin
            released = 1'b1;
            key      = code - RELEASE_BIT;
        end
        if (key > SC_LAST)
            return;
        if (key == SC_LSHIFT || key == SC_RSHIFT)
        begin
            shift_on = !released;
            return;
        end
        if (released)
            return;
        if (key == SC_BACKSPACE)
        begin
            if (line_fill != 0)
            begin
                line_fill--;
                fresh_outputs.push_back('{sle_pkg::KIND_ERASE, 7'd0, 6'd0, 1'b1});
            end
            return;
        end
        if (key == SC_ENTER)
        begin
            fresh_outputs.push_back('{sle_pkg::KIND_NEWLINE, 7'd0, 6'(line_fill),
                                      line_fill == 0});
            for (int i = 0; i < line_fill; i++)
                fresh_outputs.push_back('{sle_pkg::KIND_LINE, typed_line[i], 6'd0,
                                          i == line_fill - 1});
            line_fill = 0;
            return;
        end
        if (line_fill >= LINE_LEN)
            return;
        ch = shift_on ? 7'(shift_keys[key]) : 7'(plain_keys[key]);
        typed_line[line_fill] = ch;
        line_fill++;
        fresh_outputs.push_back('{sle_pkg::KIND_ECHO, ch, 6'd0, 1'b1});
    endfunction

    // result check first, so an item taken on the same edge queues behind
    always @(posedge clk)
    begin : monitor
        line_event_t got;
        line_event_t want;
        if (rst_n)
        begin
            if ((result_valid && !result_stall) || (scancode_valid && !scancode_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (result_valid && !result_stall)
            begin
                got = '{sle_pkg::sle_kind_t'(kind), char_code, line_length, last};
                if (awaited_outputs.size() == 0)
                begin
                    $error("unexpected result item: kind %0d, char_code %0h",
                           kind, char_code);
                    mismatches++;
                end
                else
                begin
                    want = awaited_outputs.pop_front();
                    if (got.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, got.kind);
                        mismatches++;
                    end
                    if (got.ch !== want.ch)
                    begin
                        $error("char_code: expected %0h, got %0h", want.ch, got.ch);
                        mismatches++;
                    end
                    if (got.len !== want.len)
                    begin
                        $error("line_length: expected %0d, got %0d", want.len, got.len);
                        mismatches++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, got.last);
                        mismatches++;
                    end
                end
            end
            if (scancode_valid && !scancode_stall)
            begin
                fresh_outputs.delete();
                predict_keystroke(scancode);
                if (cur_typed)
                begin
                    if (cur_has_event)
                        awaited_outputs.push_back(cur_event);
                end
                else
                begin
                    foreach (fresh_outputs[i])
                        awaited_outputs.push_back(fresh_outputs[i]);
                end
            end
        end
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // receiver stalls in bursts
    initial
    begin : stall_driver
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm_tail && $urandom_range(0, 7) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_code(input logic [7:0] code, input logic typed = 1'b0,
                             input logic has_event = 1'b0,
                             input line_event_t ev = '0);
        if (!calm_tail && $urandom_range(0, 5) == 0)
        begin
            scancode_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        scancode_valid <= 1'b1;
        scancode       <= code;
        cur_typed      <= typed;
        cur_has_event  <= has_event;
        cur_event      <= ev;
        do
            @(posedge clk);
        while (!(scancode_valid && !scancode_stall));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_line_drained();
        scancode_valid <= 1'b0;
        while (awaited_outputs.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_keystroke();
        int         pick;
        logic [7:0] key;
        pick = $urandom_range(0, 99);
        key  = 8'($urandom_range(0, 57));
        if (pick < 50)
        begin
            send_code(key);
            if ($urandom_range(0, 1) == 1)
                send_code(RELEASE_BIT | key);
        end
        else if (pick < 60)
        begin
            send_code(SC_BACKSPACE);
        end
        else if (pick < 66)
        begin
            send_code(SC_ENTER);
        end
        else if (pick < 74)
        begin
            send_code(($urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT)
                      | ($urandom_range(0, 1) ? RELEASE_BIT : 8'h00));
        end
        else if (pick < 87)
        begin
            send_code(RELEASE_BIT | key);
        end
        else
        begin
            send_code(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin : stimulus
        int  base;
        bit  paused;
        rst_n          = 1'b0;
        scancode_valid = 1'b0;
        scancode       = 8'h00;
        cur_typed      = 1'b0;
        cur_has_event  = 1'b0;
        cur_event      = '0;
        calm_tail      = 1'b0;
        shift_on       = 1'b0;
        line_fill      = 0;
        mismatches     = 0;
        quiet_cycles   = 0;
        items_sent     = 0;
        paused         = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_code(directed_rows[i].code, directed_rows[i].typed,
                      directed_rows[i].has_event, directed_rows[i].ev);

        // fill the line, overflow it by one, then submit it whole
        repeat (LINE_LEN + 1)
            send_code(SC_FIRST_LETTER + 8'($urandom_range(0, 9)));
        send_code(SC_ENTER);
        wait_line_drained();

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            if (!paused && items_sent - base >= RANDOM_ITEMS / 2)
            begin
                wait_line_drained();
                paused = 1'b1;
            end
            if (items_sent - base >= RANDOM_ITEMS - CALM_ITEMS)
                calm_tail = 1'b1;
            random_keystroke();
        end

        scancode_valid <= 1'b0;
        while (awaited_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> scancode_to_ascii_line_editor_core.f
+incdir+rtl
rtl/sle_pkg.sv
rtl/sle_datapath.sv
rtl/sle_ctrl.sv
rtl/scancode_to_ascii_line_editor_core.sv
dv/tb_top.sv
